[sv/multirate_sensor_history_assert.svh]
// Assertion macros shared by the multirate sensor history RTL.
// Relies on a clock named clock and a synchronous reset named reset in scope.
`ifndef MULTIRATE_SENSOR_HISTORY_ASSERT_SVH
`define MULTIRATE_SENSOR_HISTORY_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define MSH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition must never be seen outside reset
`define MSH_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define MSH_ASSERT(lbl, prop, msg)
`define MSH_NEVER(lbl, cond, msg)
`endif

`endif

[sv/msh_pkg.sv]
// Package for the multirate sensor history: sizes, codes, item structs, the
// constant-divisor helpers and the ring address helper. No dependencies.
package msh_pkg;

   localparam int FINE_DEPTH   = 64;
   localparam int MEDIUM_DEPTH = 64;
   localparam int COARSE_DEPTH = 64;

   localparam int FINE_AW   = $clog2(FINE_DEPTH);
   localparam int MEDIUM_AW = $clog2(MEDIUM_DEPTH);
   localparam int COARSE_AW = $clog2(COARSE_DEPTH);
   localparam int FINE_CW   = $clog2(FINE_DEPTH + 1);
   localparam int MEDIUM_CW = $clog2(MEDIUM_DEPTH + 1);
   localparam int COARSE_CW = $clog2(COARSE_DEPTH + 1);
   // common width for ring pointer arithmetic, holds 2*depth for depth up to 1024
   localparam int RING_W = 12;

   localparam int VALUE_W      = 14;
   localparam int SEL_W        = 2;
   localparam int IDX_W        = 6;
   localparam int MEDIUM_SUM_W = 18;
   localparam int COARSE_SUM_W = 22;
   localparam int MEDIUM_CD_W  = 5;
   localparam int COARSE_CD_W  = 8;
   localparam int TIME_W       = 32;

   localparam logic [MEDIUM_CD_W-1:0]  MEDIUM_RELOAD  = 5'd23;
   localparam logic [COARSE_CD_W-1:0]  COARSE_RELOAD  = 8'd215;
   localparam logic [MEDIUM_SUM_W-1:0] MEDIUM_SUM_MAX = 18'h3FFFF;
   localparam int TICK_SECONDS = 5;

   // floor(x/3) = (x*43691)>>17 exact for 15-bit x (sum/24 = (sum>>3)/3)
   localparam int MEDIUM_RECIP = 43691;
   // floor(x/27) = (x*621379)>>24 exact for 19-bit x (sum/216 = (sum>>3)/27)
   localparam int COARSE_RECIP = 621379;

   localparam int SECS_PER_MIN   = 60;
   localparam int MINS_PER_HOUR  = 60;
   localparam int HOURS_PER_DAY  = 24;

   localparam int CMDQ_DEPTH = 4;
   localparam int OUTQ_DEPTH = 4;

   localparam logic [SEL_W-1:0] GRAPH_FINE   = 2'd0;
   localparam logic [SEL_W-1:0] GRAPH_MEDIUM = 2'd1;
   localparam logic [SEL_W-1:0] GRAPH_COARSE = 2'd2;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [15:0] days;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } uptime_type;

   // one classified item on its way from front to back
   typedef struct packed {
      cmd_type             cmd;
      logic [VALUE_W-1:0]  sample;
      logic                medium_push;
      logic                coarse_push;
      logic [VALUE_W-1:0]  medium_avg;
      logic [VALUE_W-1:0]  coarse_avg;
      logic [SEL_W-1:0]    sel;
      logic [IDX_W-1:0]    idx;
      uptime_type          up;
      logic [TIME_W-1:0]   medium_stamp;
      logic [TIME_W-1:0]   coarse_stamp;
   } op_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               medium_pushed;
      logic               coarse_pushed;
      uptime_type         up;
      logic [TIME_W-1:0]  medium_stamp;
      logic [TIME_W-1:0]  coarse_stamp;
   } rsp_type;

   function automatic logic [VALUE_W-1:0] medium_average(
      input logic [MEDIUM_SUM_W-1:0] sum);
      logic [31:0] prod;
      prod = 32'(sum[MEDIUM_SUM_W-1:3]) * 32'(MEDIUM_RECIP);
      return prod[VALUE_W+16:17];
   endfunction

   // quotient fits in 14 bits: the sum covers at most 216 samples of 14 bits
   function automatic logic [VALUE_W-1:0] coarse_average(
      input logic [COARSE_SUM_W-1:0] sum);
      logic [39:0] prod;
      prod = 40'(sum[COARSE_SUM_W-1:3]) * 40'(COARSE_RECIP);
      return prod[VALUE_W+23:24];
   endfunction

   // newest entry sits just below the write pointer
   function automatic logic [RING_W-1:0] ring_addr(
      input logic [RING_W-1:0] wp,
      input logic [RING_W-1:0] idx,
      input logic [RING_W-1:0] depth);
      logic [RING_W-1:0] t;
      t = wp + depth - 12'd1 - idx;
      if (t >= depth) begin
         t = t - depth;
      end
      return t;
   endfunction

endpackage

[sv/msh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the three history buffers.
module msh_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/msh_front.sv]
// Front end: takes items, runs both decimators, the uptime split and the
// stamps, and writes one classified op per item into the command queue. Uses msh_pkg.
`include "multirate_sensor_history_assert.svh"

module msh_front import msh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                req_command,
   input  logic [VALUE_W-1:0]  req_co2_ppm,
   input  logic [SEL_W-1:0]    req_graph_select,
   input  logic [IDX_W-1:0]    req_read_index,
   input  logic                q_full,
   output logic                q_push,
   output op_type              q_op
);

   logic [MEDIUM_CD_W-1:0]  medium_cd_ff, medium_cd_in;
   logic [COARSE_CD_W-1:0]  coarse_cd_ff, coarse_cd_in;
   logic [MEDIUM_SUM_W-1:0] medium_sum_ff, medium_sum_in;
   logic [COARSE_SUM_W-1:0] coarse_sum_ff, coarse_sum_in;
   logic [TIME_W-1:0]       uptime_ff, uptime_in;
   logic [TIME_W-1:0]       medium_time_ff, medium_time_in;
   logic [TIME_W-1:0]       coarse_time_ff, coarse_time_in;
   uptime_type              up_ff, up_in;

   logic                    accept;
   logic                    is_tick;
   logic                    tick;
   logic                    medium_zero;
   logic                    coarse_zero;
   logic [MEDIUM_SUM_W-1:0] medium_base;
   logic [COARSE_SUM_W-1:0] coarse_base;
   logic [MEDIUM_SUM_W:0]   medium_acc;
   logic [TIME_W:0]         uptime_acc;
   logic [6:0]              sec_acc;

   assign accept      = push & ~q_full;
   assign is_tick     = (cmd_type'(req_command) == CMD_TICK);
   assign tick        = accept & is_tick;
   assign medium_zero = (medium_cd_ff == '0);
   assign coarse_zero = (coarse_cd_ff == '0);
   assign full        = q_full;
   assign q_push      = accept;

   // decimators: the counter is looked at before the sample is added
   always_comb begin
      medium_cd_in   = medium_cd_ff;
      coarse_cd_in   = coarse_cd_ff;
      medium_sum_in  = medium_sum_ff;
      coarse_sum_in  = coarse_sum_ff;
      medium_time_in = medium_time_ff;
      coarse_time_in = coarse_time_ff;
      medium_base    = medium_zero ? '0 : medium_sum_ff;
      coarse_base    = coarse_zero ? '0 : coarse_sum_ff;
      medium_acc     = {1'b0, medium_base} + 19'(req_co2_ppm);
      if (tick) begin
         medium_cd_in  = medium_zero ? MEDIUM_RELOAD : medium_cd_ff - 5'd1;
         coarse_cd_in  = coarse_zero ? COARSE_RELOAD : coarse_cd_ff - 8'd1;
         medium_sum_in = medium_acc[MEDIUM_SUM_W] ? MEDIUM_SUM_MAX
                                                  : medium_acc[MEDIUM_SUM_W-1:0];
         coarse_sum_in = coarse_base + 22'(req_co2_ppm);
         if (medium_zero) begin
            medium_time_in = uptime_ff;
         end
         if (coarse_zero) begin
            coarse_time_in = uptime_ff;
         end
      end
   end

   // uptime kept split incrementally; a 32-bit wrap leaves less than one tick
   always_comb begin
      uptime_in  = uptime_ff;
      up_in      = up_ff;
      uptime_acc = {1'b0, uptime_ff} + 33'(TICK_SECONDS);
      sec_acc    = {1'b0, up_ff.seconds} + 7'(TICK_SECONDS);
      if (tick) begin
         uptime_in = uptime_acc[TIME_W-1:0];
         if (uptime_acc[TIME_W]) begin
            up_in         = '0;
            up_in.seconds = uptime_acc[5:0];
         end else if (sec_acc >= 7'(SECS_PER_MIN)) begin
            up_in.seconds = 6'(sec_acc - 7'(SECS_PER_MIN));
            if (up_ff.minutes == 6'(MINS_PER_HOUR - 1)) begin
               up_in.minutes = '0;
               if (up_ff.hours == 5'(HOURS_PER_DAY - 1)) begin
                  up_in.hours = '0;
                  up_in.days  = up_ff.days + 16'd1;
               end else begin
                  up_in.hours = up_ff.hours + 5'd1;
               end
            end else begin
               up_in.minutes = up_ff.minutes + 6'd1;
            end
         end else begin
            up_in.seconds = sec_acc[5:0];
         end
      end
   end

   always_comb begin
      q_op.cmd          = cmd_type'(req_command);
      q_op.sample       = req_co2_ppm;
      q_op.medium_push  = is_tick & medium_zero;
      q_op.coarse_push  = is_tick & coarse_zero;
      q_op.medium_avg   = medium_average(medium_sum_ff);
      q_op.coarse_avg   = coarse_average(coarse_sum_ff);
      q_op.sel          = req_graph_select;
      q_op.idx          = req_read_index;
      q_op.up           = up_in;
      q_op.medium_stamp = medium_time_in;
      q_op.coarse_stamp = coarse_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         medium_cd_ff   <= '0;
         coarse_cd_ff   <= '0;
         medium_sum_ff  <= '0;
         coarse_sum_ff  <= '0;
         uptime_ff      <= '0;
         medium_time_ff <= '0;
         coarse_time_ff <= '0;
         up_ff          <= '0;
      end else begin
         medium_cd_ff   <= medium_cd_in;
         coarse_cd_ff   <= coarse_cd_in;
         medium_sum_ff  <= medium_sum_in;
         coarse_sum_ff  <= coarse_sum_in;
         uptime_ff      <= uptime_in;
         medium_time_ff <= medium_time_in;
         coarse_time_ff <= coarse_time_in;
         up_ff          <= up_in;
      end
   end

   `MSH_NEVER(a_medium_cd_range, medium_cd_ff > MEDIUM_RELOAD, "medium countdown out of range")
   `MSH_NEVER(a_coarse_cd_range, coarse_cd_ff > COARSE_RELOAD, "coarse countdown out of range")
   `MSH_ASSERT(a_coarse_stamp, tick && coarse_zero |=> coarse_time_ff == $past(uptime_ff), "coarse stamp not taken from uptime")

endmodule

[sv/msh_cmdq.sv]
// Short command queue between the front end and the history back end.
// Uses msh_pkg for the op struct and depth.
module msh_cmdq import msh_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   q_push,
   input  op_type q_wdata,
   output logic   q_full,
   input  logic   q_pop,
   output op_type q_rdata,
   output logic   q_empty
);

   localparam int CQ_AW = $clog2(CMDQ_DEPTH);
   localparam int CQ_CW = $clog2(CMDQ_DEPTH + 1);

   op_type           mem_ff [CMDQ_DEPTH];
   logic [CQ_AW-1:0] wp_ff, wp_in;
   logic [CQ_AW-1:0] rp_ff, rp_in;
   logic [CQ_CW-1:0] count_ff, count_in;

   assign q_full  = (count_ff == CQ_CW'(CMDQ_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_rdata = mem_ff[rp_ff];

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      count_in = count_ff;
      if (q_push) begin
         wp_in = (wp_ff == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (q_pop) begin
         rp_in = (rp_ff == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (q_push & ~q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop & ~q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wp_ff] <= q_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

endmodule

[sv/msh_back.sv]
// Back end: executes queued ops on the three ring-buffer histories and
// queues the result items. Uses msh_pkg and msh_ram.
`include "multirate_sensor_history_assert.svh"

module msh_back import msh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  op_type  q_rdata,
   output logic    q_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp
);

   localparam int OQ_AW = $clog2(OUTQ_DEPTH);
   localparam int OQ_CW = $clog2(OUTQ_DEPTH + 1);

   logic [FINE_AW-1:0]   fine_wp_ff, fine_wp_in;
   logic [MEDIUM_AW-1:0] medium_wp_ff, medium_wp_in;
   logic [COARSE_AW-1:0] coarse_wp_ff, coarse_wp_in;
   logic [FINE_CW-1:0]   fine_cnt_ff, fine_cnt_in;
   logic [MEDIUM_CW-1:0] medium_cnt_ff, medium_cnt_in;
   logic [COARSE_CW-1:0] coarse_cnt_ff, coarse_cnt_in;

   op_type               b_op_ff;
   logic                 b_valid_ff;
   logic                 b_hit_ff, b_hit_in;

   rsp_type              oq_mem_ff [OUTQ_DEPTH];
   logic [OQ_AW-1:0]     oq_wp_ff, oq_wp_in;
   logic [OQ_AW-1:0]     oq_rp_ff, oq_rp_in;
   logic [OQ_CW-1:0]     oq_count_ff, oq_count_in;

   logic                 issue;
   logic                 issue_tick;
   logic [OQ_CW:0]       oq_load;
   logic                 oq_pop;
   logic [RING_W-1:0]    fine_ra, medium_ra, coarse_ra;
   logic [VALUE_W-1:0]   fine_rd, medium_rd, coarse_rd;
   logic [VALUE_W-1:0]   sel_rd;
   rsp_type              b_rsp;

   // room is reserved for the op already in the read stage
   assign oq_load    = {1'b0, oq_count_ff} + {{OQ_CW{1'b0}}, b_valid_ff};
   assign issue      = ~q_empty & (oq_load < (OQ_CW + 1)'(OUTQ_DEPTH));
   assign q_pop      = issue;
   assign issue_tick = issue & (q_rdata.cmd == CMD_TICK);

   assign fine_ra   = ring_addr(RING_W'(fine_wp_ff), RING_W'(q_rdata.idx),
                                RING_W'(FINE_DEPTH));
   assign medium_ra = ring_addr(RING_W'(medium_wp_ff), RING_W'(q_rdata.idx),
                                RING_W'(MEDIUM_DEPTH));
   assign coarse_ra = ring_addr(RING_W'(coarse_wp_ff), RING_W'(q_rdata.idx),
                                RING_W'(COARSE_DEPTH));

   // entries past the fill count read as zero through the hit flag, not through a RAM reset
   always_comb begin
      b_hit_in = 1'b0;
      if (q_rdata.cmd == CMD_READ) begin
         case (q_rdata.sel)
            GRAPH_FINE:   b_hit_in = RING_W'(q_rdata.idx) < RING_W'(fine_cnt_ff);
            GRAPH_MEDIUM: b_hit_in = RING_W'(q_rdata.idx) < RING_W'(medium_cnt_ff);
            GRAPH_COARSE: b_hit_in = RING_W'(q_rdata.idx) < RING_W'(coarse_cnt_ff);
            default:      b_hit_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      fine_wp_in    = fine_wp_ff;
      medium_wp_in  = medium_wp_ff;
      coarse_wp_in  = coarse_wp_ff;
      fine_cnt_in   = fine_cnt_ff;
      medium_cnt_in = medium_cnt_ff;
      coarse_cnt_in = coarse_cnt_ff;
      if (issue_tick) begin
         fine_wp_in = (fine_wp_ff == FINE_AW'(FINE_DEPTH - 1)) ? '0 : fine_wp_ff + 1'b1;
         if (fine_cnt_ff != FINE_CW'(FINE_DEPTH)) begin
            fine_cnt_in = fine_cnt_ff + 1'b1;
         end
         if (q_rdata.medium_push) begin
            medium_wp_in = (medium_wp_ff == MEDIUM_AW'(MEDIUM_DEPTH - 1)) ? '0
                                                                        : medium_wp_ff + 1'b1;
            if (medium_cnt_ff != MEDIUM_CW'(MEDIUM_DEPTH)) begin
               medium_cnt_in = medium_cnt_ff + 1'b1;
            end
         end
         if (q_rdata.coarse_push) begin
            coarse_wp_in = (coarse_wp_ff == COARSE_AW'(COARSE_DEPTH - 1)) ? '0
                                                                        : coarse_wp_ff + 1'b1;
            if (coarse_cnt_ff != COARSE_CW'(COARSE_DEPTH)) begin
               coarse_cnt_in = coarse_cnt_ff + 1'b1;
            end
         end
      end
   end

   msh_ram #(.WIDTH(VALUE_W), .DEPTH(FINE_DEPTH)) u_fine_ram (
      .clock   (clock),
      .wr_en   (issue_tick),
      .wr_addr (fine_wp_ff),
      .wr_data (q_rdata.sample),
      .rd_en   (issue),
      .rd_addr (fine_ra[FINE_AW-1:0]),
      .rd_data (fine_rd)
   );

   msh_ram #(.WIDTH(VALUE_W), .DEPTH(MEDIUM_DEPTH)) u_medium_ram (
      .clock   (clock),
      .wr_en   (issue_tick & q_rdata.medium_push),
      .wr_addr (medium_wp_ff),
      .wr_data (q_rdata.medium_avg),
      .rd_en   (issue),
      .rd_addr (medium_ra[MEDIUM_AW-1:0]),
      .rd_data (medium_rd)
   );

   msh_ram #(.WIDTH(VALUE_W), .DEPTH(COARSE_DEPTH)) u_coarse_ram (
      .clock   (clock),
      .wr_en   (issue_tick & q_rdata.coarse_push),
      .wr_addr (coarse_wp_ff),
      .wr_data (q_rdata.coarse_avg),
      .rd_en   (issue),
      .rd_addr (coarse_ra[COARSE_AW-1:0]),
      .rd_data (coarse_rd)
   );

   always_comb begin
      case (b_op_ff.sel)
         GRAPH_FINE:   sel_rd = fine_rd;
         GRAPH_MEDIUM: sel_rd = medium_rd;
         GRAPH_COARSE: sel_rd = coarse_rd;
         default:      sel_rd = '0;
      endcase
      b_rsp.read_value    = b_hit_ff ? sel_rd : '0;
      b_rsp.medium_pushed = (b_op_ff.cmd == CMD_TICK) & b_op_ff.medium_push;
      b_rsp.coarse_pushed = (b_op_ff.cmd == CMD_TICK) & b_op_ff.coarse_push;
      b_rsp.up            = b_op_ff.up;
      b_rsp.medium_stamp  = b_op_ff.medium_stamp;
      b_rsp.coarse_stamp  = b_op_ff.coarse_stamp;
   end

   // result queue
   assign empty  = (oq_count_ff == '0);
   assign oq_pop = pop & ~empty;
   assign rsp    = oq_mem_ff[oq_rp_ff];

   always_comb begin
      oq_wp_in    = oq_wp_ff;
      oq_rp_in    = oq_rp_ff;
      oq_count_in = oq_count_ff;
      if (b_valid_ff) begin
         oq_wp_in = (oq_wp_ff == OQ_AW'(OUTQ_DEPTH - 1)) ? '0 : oq_wp_ff + 1'b1;
      end
      if (oq_pop) begin
         oq_rp_in = (oq_rp_ff == OQ_AW'(OUTQ_DEPTH - 1)) ? '0 : oq_rp_ff + 1'b1;
      end
      if (b_valid_ff & ~oq_pop) begin
         oq_count_in = oq_count_ff + 1'b1;
      end else if (oq_pop & ~b_valid_ff) begin
         oq_count_in = oq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_op_ff  <= q_rdata;
         b_hit_ff <= b_hit_in;
      end
      if (b_valid_ff) begin
         oq_mem_ff[oq_wp_ff] <= b_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_wp_ff    <= '0;
         medium_wp_ff  <= '0;
         coarse_wp_ff  <= '0;
         fine_cnt_ff   <= '0;
         medium_cnt_ff <= '0;
         coarse_cnt_ff <= '0;
         b_valid_ff    <= 1'b0;
         oq_wp_ff      <= '0;
         oq_rp_ff      <= '0;
         oq_count_ff   <= '0;
      end else begin
         fine_wp_ff    <= fine_wp_in;
         medium_wp_ff  <= medium_wp_in;
         coarse_wp_ff  <= coarse_wp_in;
         fine_cnt_ff   <= fine_cnt_in;
         medium_cnt_ff <= medium_cnt_in;
         coarse_cnt_ff <= coarse_cnt_in;
         b_valid_ff    <= issue;
         oq_wp_ff      <= oq_wp_in;
         oq_rp_ff      <= oq_rp_in;
         oq_count_ff   <= oq_count_in;
      end
   end

   `MSH_NEVER(a_oq_overflow, b_valid_ff && oq_count_ff == OQ_CW'(OUTQ_DEPTH), "result queue transfer while full")
   `MSH_NEVER(a_tick_no_hit, b_valid_ff && b_op_ff.cmd == CMD_TICK && b_hit_ff, "tick flagged as read hit")
   `MSH_ASSERT(a_fine_filled, issue_tick |=> fine_cnt_ff != '0, "fine history count stuck at zero after tick")

endmodule

[sv/multirate_sensor_history.sv]
// Top level of the multirate sensor history; joins front end, command
// queue and history back end. Uses msh_pkg, msh_front, msh_cmdq, msh_back.
//
// Takes one tick or read item per clock while full is low and returns one
// result item per item, in order. Sustained rate is one item per cycle while
// results are taken. A result becomes visible once its item has passed three
// registers (command queue, history memory read with registered data, result
// queue); the read stage waits for result queue room. Each history is a
// ring buffer in a single-port-write, registered-read RAM; entries beyond the
// fill count read as zero, so no clearing pass is needed after reset. The
// 24- and 216-sample averages use reciprocal multiplies in the front end, and
// the uptime split is kept as running counters. full rises when the four-deep
// command queue fills, which happens only while results are not being taken.
module multirate_sensor_history import msh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                req_command,
   input  logic [VALUE_W-1:0]  req_co2_ppm,
   input  logic [SEL_W-1:0]    req_graph_select,
   input  logic [IDX_W-1:0]    req_read_index,
   output logic                empty,
   input  logic                pop,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_medium_pushed,
   output logic                rsp_coarse_pushed,
   output logic [5:0]          rsp_up_seconds,
   output logic [5:0]          rsp_up_minutes,
   output logic [4:0]          rsp_up_hours,
   output logic [15:0]         rsp_up_days,
   output logic [TIME_W-1:0]   rsp_medium_stamp,
   output logic [TIME_W-1:0]   rsp_coarse_stamp
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   op_type  q_wdata;
   op_type  q_rdata;
   rsp_type rsp;

   msh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_command      (req_command),
      .req_co2_ppm      (req_co2_ppm),
      .req_graph_select (req_graph_select),
      .req_read_index   (req_read_index),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_op             (q_wdata)
   );

   msh_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_empty (q_empty)
   );

   msh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_rdata (q_rdata),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp     (rsp)
   );

   assign rsp_read_value    = rsp.read_value;
   assign rsp_medium_pushed = rsp.medium_pushed;
   assign rsp_coarse_pushed = rsp.coarse_pushed;
   assign rsp_up_seconds    = rsp.up.seconds;
   assign rsp_up_minutes    = rsp.up.minutes;
   assign rsp_up_hours      = rsp.up.hours;
   assign rsp_up_days       = rsp.up.days;
   assign rsp_medium_stamp  = rsp.medium_stamp;
   assign rsp_coarse_stamp  = rsp.coarse_stamp;

endmodule
